@@ rtl/core/fsst_pkg.sv @@
`default_nettype none

package fsst_pkg;

  // default table geometry
  localparam int SLOTS_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // request field widths
  localparam int ACTION_W = 2;
  localparam int KEY_IN_W = 32;

  // result field widths
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // packed stream widths, rounded up to whole bytes
  localparam int S_DATA_W = ((ACTION_W + KEY_IN_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((SLOT_W + STATUS_W + COUNT_W + 7) / 8) * 8;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/fsst_ram.sv @@
`default_nettype none

module fsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/fixed_slot_set_table.sv @@
// A new request is accepted only while the sequencer is idle, after the last write-back.
// Each request reads every key from the key RAM once through its single read port,
// then writes back. A result left waiting on the output stalls the next write-back,
// not the next acceptance. Reset (rst, synchronous, active high) clears all valid bits,
// the member count, the sequencer and the output valid flag; the key RAM is not cleared.
`default_nettype none

module fixed_slot_set_table
  import fsst_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // action[1:0], key[33:2], zero pad
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata    // slot[4:0], status[6:5], member_count[11:7], zero pad
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SW    = CNT_W + SLOT_W;
  localparam int KXW   = KEY_WIDTH + KEY_IN_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]           state;
  logic [ACTION_W-1:0]  action;
  logic [KEY_WIDTH-1:0] key;
  logic [CNT_W-1:0]     rd_cnt;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [SLOTS-1:0]     valid;
  logic [CNT_W-1:0]     count;
  logic [KEY_WIDTH-1:0] rdata;
  logic [KXW-1:0]       key_wide;
  logic                 req_acc;
  logic                 out_free;
  logic                 finish;
  logic                 ram_we;

  // result selection
  logic                 has_slot;
  logic [IDX_W-1:0]     sel_idx;
  logic [STATUS_W-1:0]  res_status;
  logic [CNT_W-1:0]     count_next;
  logic [SLOTS-1:0]     valid_next;
  logic [SW-1:0]        slot_wide;
  logic [SW-1:0]        cnt_wide;

  logic [SLOT_W-1:0]    out_slot;
  logic [STATUS_W-1:0]  out_status;
  logic [COUNT_W-1:0]   out_count;

  assign key_wide = {{KEY_WIDTH{1'b0}}, s_tdata[ACTION_W +: KEY_IN_W]};
  assign s_tready = (state == S_IDLE);
  assign req_acc  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == S_WRITE) && out_free;

  // key store
  fsst_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (key),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  // write-back decision for the finished scan
  always_comb begin
    has_slot   = 1'b0;
    sel_idx    = hit_idx;
    res_status = ST_DONE;
    count_next = count;
    valid_next = valid;
    ram_we     = 1'b0;
    if (action == ACT_INSERT) begin
      if (hit_found) begin
        has_slot   = 1'b1;
        res_status = ST_PRESENT;
      end else if (free_found) begin
        has_slot             = 1'b1;
        sel_idx              = free_idx;
        ram_we               = finish;
        valid_next[free_idx] = 1'b1;
        count_next           = count + CNT_W'(1);
      end else begin
        res_status = ST_FULL;
      end
    end else if (action == ACT_REMOVE) begin
      if (hit_found) begin
        has_slot            = 1'b1;
        valid_next[hit_idx] = 1'b0;
        count_next          = count - CNT_W'(1);
      end else begin
        res_status = ST_MISS;
      end
    end else begin
      if (hit_found) begin
        has_slot = 1'b1;
      end else begin
        res_status = ST_MISS;
      end
    end
    slot_wide = SW'(sel_idx) + SW'(1);
    cnt_wide  = SW'(count_next);
  end

  // sequencer, scan and write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_cnt     <= '0;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      valid      <= '0;
      count      <= '0;
    end else begin
      cmp_vld <= (state == S_SCAN) && (rd_cnt != CNT_W'(SLOTS));
      cmp_idx <= rd_cnt[IDX_W-1:0];
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            action     <= s_tdata[ACTION_W-1:0];
            key        <= key_wide[KEY_WIDTH-1:0];
            rd_cnt     <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_cnt != CNT_W'(SLOTS)) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end else begin
            state <= S_WRITE;
          end
          // compare the key read in the previous cycle
          if (cmp_vld) begin
            if (valid[cmp_idx] && (rdata == key) && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
            end
            if (!valid[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            valid <= valid_next;
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_slot   <= has_slot ? slot_wide[SLOT_W-1:0] : '0;
      out_status <= res_status;
      out_count  <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign m_tdata = {(M_DATA_W - SLOT_W - STATUS_W - COUNT_W)'(0),
                    out_count, out_status, out_slot};

  // checks
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(count))
    else $error("member count differs from valid bits");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("member count above table size");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (!valid[free_idx] && !hit_found))
    else $error("key written over a live slot or a present key");

  a_present_keeps: assert property (@(posedge clk) disable iff (rst)
    (finish && (res_status == ST_PRESENT)) |=> $stable(valid))
    else $error("present key changed the table");

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (rd_cnt == CNT_W'(SLOTS)))
    else $error("write-back before the scan finished");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
  import fsst_pkg::*;

  // action code the block does not define, handled as a lookup
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  localparam int LATENCY        = SLOTS_DEF + 3;
  localparam int RANDOM_ITEMS   = 650;
  localparam int POOL_SIZE      = 24;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_IN_W-1:0] key;
  } table_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  fixed_slot_set_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // shadow copy of the table
  logic                     shadow_valid [SLOTS_DEF];
  logic [KEY_WIDTH_DEF-1:0] shadow_key   [SLOTS_DEF];

  table_req_t    pending_requests [$];
  table_result_t expected_results [$];
  logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];

  logic in_fire = 1'b0;
  int   accepted_cnt = 0;
  int   err_cnt = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   idle_cycles = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the shadow table and return what the block should report
  function automatic table_result_t table_apply(table_req_t r);
    table_result_t            res;
    logic [KEY_WIDTH_DEF-1:0] k;
    int                       hit;
    int                       free_idx;
    int                       n;
    int                       i;
    k = r.key[KEY_WIDTH_DEF-1:0];
    hit = SLOTS_DEF;
    free_idx = SLOTS_DEF;
    for (i = SLOTS_DEF - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == k) hit = i;
      if (!shadow_valid[i]) free_idx = i;
    end
    res.slot = '0;
    res.status = ST_DONE;
    case (r.action)
      ACT_INSERT: begin
        if (hit < SLOTS_DEF) begin
          res.slot = SLOT_W'(hit + 1);
          res.status = ST_PRESENT;
        end else if (free_idx < SLOTS_DEF) begin
          shadow_key[free_idx] = k;
          shadow_valid[free_idx] = 1'b1;
          res.slot = SLOT_W'(free_idx + 1);
        end else begin
          res.status = ST_FULL;
        end
      end
      ACT_REMOVE: begin
        if (hit < SLOTS_DEF) begin
          shadow_valid[hit] = 1'b0;
          res.slot = SLOT_W'(hit + 1);
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        // lookup, and the spare code behaves the same
        if (hit < SLOTS_DEF) res.slot = SLOT_W'(hit + 1);
        else res.status = ST_MISS;
      end
    endcase
    n = 0;
    for (i = 0; i < SLOTS_DEF; i++) begin
      if (shadow_valid[i]) n++;
    end
    res.count = COUNT_W'(n);
    return res;
  endfunction

  task automatic queue_request(logic [ACTION_W-1:0] action, logic [KEY_IN_W-1:0] key);
    table_req_t r;
    r.action = action;
    r.key = key;
    pending_requests.push_back(r);
  endtask

  task automatic note_failure(string msg);
    if (err_cnt < REPORT_LIMIT) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // idle length: mostly none or short, now and then long, none in calm stretches
  function automatic int idle_gap();
    int r;
    if ((accepted_cnt % 200) >= 150) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // request driver
  always @(negedge clk) begin
    table_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_requests.size() > 0) begin
        nxt = pending_requests.pop_front();
        s_tdata <= S_DATA_W'({nxt.key, nxt.action});
        s_tvalid <= 1'b1;
        send_gap <= idle_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left <= idle_gap();
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    table_req_t    req;
    table_result_t got;
    table_result_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.slot   = m_tdata[SLOT_W-1:0];
        got.status = m_tdata[SLOT_W +: STATUS_W];
        got.count  = m_tdata[SLOT_W+STATUS_W +: COUNT_W];
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result slot %0d status %0d count %0d",
                                 got.slot, got.status, got.count));
        end else begin
          want = expected_results.pop_front();
          if (got != want)
            note_failure($sformatf(
              "expected slot %0d status %0d count %0d, got slot %0d status %0d count %0d",
              want.slot, want.status, want.count, got.slot, got.status, got.count));
        end
      end
      if (s_tvalid && s_tready) begin
        req.action = s_tdata[ACTION_W-1:0];
        req.key    = s_tdata[ACTION_W +: KEY_IN_W];
        expected_results.push_back(table_apply(req));
        accepted_cnt++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
      $display("fixed_slot_set_table regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    int r;
    bit fill_phase;
    logic [ACTION_W-1:0] act;
    logic [KEY_IN_W-1:0] k;

    for (i = 0; i < SLOTS_DEF; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // directed: misses on an empty table, key extremes, re-insert, reuse of a freed slot
    queue_request(ACT_LOOKUP, '0);
    queue_request(ACT_REMOVE, '1);
    queue_request(ACT_INSERT, '0);
    queue_request(ACT_INSERT, '1);
    queue_request(ACT_INSERT, '0);
    queue_request(ACT_LOOKUP, '1);
    queue_request(ACT_REMOVE, '0);
    queue_request(ACT_LOOKUP, '0);
    queue_request(ACT_INSERT, '0);
    queue_request(ACT_SPARE, '1);
    // fill the table, then overflow it
    for (i = 0; i < SLOTS_DEF - 2; i++)
      queue_request(ACT_INSERT, KEY_IN_W'(32'h5a5a_0000 | (32'h1 << i)));
    queue_request(ACT_INSERT, 32'h0f0f_0f0f);
    queue_request(ACT_SPARE, 32'h0f0f_0f0f);

    // random: alternating fill-heavy and drain-heavy stretches over a small key pool
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      fill_phase = ((i / 50) % 2) == 1;
      r = $urandom_range(0, 99);
      if (fill_phase)
        act = (r < 55) ? ACT_INSERT : (r < 75) ? ACT_LOOKUP : (r < 95) ? ACT_REMOVE : ACT_SPARE;
      else
        act = (r < 20) ? ACT_INSERT : (r < 45) ? ACT_LOOKUP : (r < 95) ? ACT_REMOVE : ACT_SPARE;
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      queue_request(act, k);
    end

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // drain
    while (pending_requests.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (expected_results.size() > 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    if (err_cnt == 0) begin
      $display("fixed_slot_set_table regression: pass");
    end else begin
      $display("fixed_slot_set_table regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
